[hdl/binary_blob_shape_features_defines.svh]
// ---------------------------------------------------------------------------
// Blob shape features: assertion macros
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef BINARY_BLOB_SHAPE_FEATURES_DEFINES_SVH
`define BINARY_BLOB_SHAPE_FEATURES_DEFINES_SVH

// same-cycle implication
`define BBSF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBSF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bbsf_pkg.sv]
// ---------------------------------------------------------------------------
// Blob shape features package
// Field widths, register indexes and the per-pixel context record
// ---------------------------------------------------------------------------
package bbsf_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam int unsigned CFG_SIZE_RST = 1024;

  // result fields
  localparam int unsigned LEFT_W   = 11;
  localparam int unsigned RIGHT_W  = 10;
  localparam int unsigned TOP_W    = 11;
  localparam int unsigned BOTTOM_W = 10;
  localparam int unsigned AREA_W   = 21;
  localparam int unsigned PERIM_W  = 21;
  localparam int unsigned EULER_W  = 20;

  // neighborhood of one pixel, handed from the input stage to the accumulators
  typedef struct packed {
    logic pix;
    logic up;
    logic left;
    logic upleft;
    logic col_nz;
    logic row_nz;
    logic first;
    logic last;
  } px_flags_t;

endpackage

[hdl/bbsf_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle, read returns the old data
// ---------------------------------------------------------------------------
module bbsf_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/bbsf_feat.sv]
// ---------------------------------------------------------------------------
// Blob shape feature accumulators
// Bounding box, area, 4-adjacent edge count and bit-quad sum for one frame
// ---------------------------------------------------------------------------
module bbsf_feat
  import bbsf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  px_flags_t                         flags_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]      col_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0]     row_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height_i,
  output logic [$clog2(MAX_WIDTH+1)-1:0]    min_col_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      max_col_o,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]   min_row_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]     max_row_o,
  output logic [AREA_W-1:0]                 area_o,
  output logic [PERIM_W-1:0]                perim_o,
  output logic signed [EULER_W-1:0]         euler_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned SW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HSW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW_RAW = $clog2(NPIX + 1);
  localparam int unsigned EW_RAW = $clog2(2 * NPIX + 1);
  localparam int unsigned QW_RAW = $clog2(NPIX) + 3;
  localparam int unsigned AW = (AW_RAW > AREA_W) ? AW_RAW : AREA_W + 1;
  localparam int unsigned EW = (EW_RAW > PERIM_W) ? EW_RAW : PERIM_W + 1;
  localparam int unsigned QW = (QW_RAW > EULER_W) ? QW_RAW : EULER_W + 1;
  localparam logic [AW-1:0] AREA_SAT  = AW'((64'd1 << AREA_W) - 64'd1);
  localparam logic [EW-1:0] PERIM_SAT = EW'((64'd1 << PERIM_W) - 64'd1);
  localparam logic signed [QW-1:0] EU_HI = QW'((64'sd1 <<< (EULER_W - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] EU_LO = QW'(-(64'sd1 <<< (EULER_W - 1)));

  logic [SW-1:0]  min_col_q, min_col_b;
  logic [CW-1:0]  max_col_q, max_col_b;
  logic [HSW-1:0] min_row_q, min_row_b;
  logic [RW-1:0]  max_row_q, max_row_b;
  logic [AW-1:0]  area_q, area_b, area_d;
  logic [EW-1:0]  edge_q, edge_b, edge_d;
  logic signed [QW-1:0] quad_q, quad_b, quad_d, quad_adj, euler_full;
  logic [1:0]     edge_inc;
  logic [2:0]     ones;
  logic signed [2:0] quad_delta;

  // the first pixel of a frame starts from a cleared set
  always_comb begin
    if (flags_i.first) begin
      min_col_b = width_i;
      max_col_b = '0;
      min_row_b = height_i;
      max_row_b = '0;
      area_b    = '0;
      edge_b    = '0;
      quad_b    = '0;
    end else begin
      min_col_b = min_col_q;
      max_col_b = max_col_q;
      min_row_b = min_row_q;
      max_row_b = max_row_q;
      area_b    = area_q;
      edge_b    = edge_q;
      quad_b    = quad_q;
    end
  end

  always_comb begin
    min_col_o = (flags_i.pix && (SW'(col_i) < min_col_b)) ? SW'(col_i) : min_col_b;
    max_col_o = (flags_i.pix && (col_i > max_col_b)) ? col_i : max_col_b;
    min_row_o = (flags_i.pix && (HSW'(row_i) < min_row_b)) ? HSW'(row_i) : min_row_b;
    max_row_o = (flags_i.pix && (row_i > max_row_b)) ? row_i : max_row_b;
    area_d    = area_b + AW'(flags_i.pix);

    edge_inc = {1'b0, flags_i.col_nz && (flags_i.pix != flags_i.left)}
             + {1'b0, flags_i.row_nz && (flags_i.pix != flags_i.up)};
    edge_d   = edge_b + EW'(edge_inc);

    // bit quad: single one +1, three ones -1, diagonal pair -2
    ones = 3'(flags_i.upleft) + 3'(flags_i.up) + 3'(flags_i.left) + 3'(flags_i.pix);
    quad_delta = 3'sd0;
    if (flags_i.col_nz && flags_i.row_nz) begin
      case (ones)
        3'd1:    quad_delta = 3'sd1;
        3'd3:    quad_delta = -3'sd1;
        3'd2:    quad_delta = (flags_i.upleft == flags_i.pix) ? -3'sd2 : 3'sd0;
        default: quad_delta = 3'sd0;
      endcase
    end
    quad_d = quad_b + QW'(quad_delta);

    // divide by four, rounding toward zero
    quad_adj   = quad_d + (quad_d[QW-1] ? QW'(3) : QW'(0));
    euler_full = quad_adj >>> 2;
    if (euler_full > EU_HI) begin
      euler_o = EULER_W'(EU_HI);
    end else if (euler_full < EU_LO) begin
      euler_o = EULER_W'(EU_LO);
    end else begin
      euler_o = EULER_W'(euler_full);
    end

    area_o  = (area_d > AREA_SAT) ? AREA_W'(AREA_SAT) : AREA_W'(area_d);
    perim_o = (edge_d > PERIM_SAT) ? PERIM_W'(PERIM_SAT) : PERIM_W'(edge_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_col_q <= '0;
      max_col_q <= '0;
      min_row_q <= '0;
      max_row_q <= '0;
      area_q    <= '0;
      edge_q    <= '0;
      quad_q    <= '0;
    end else if (fire_i) begin
      min_col_q <= min_col_o;
      max_col_q <= max_col_o;
      min_row_q <= min_row_o;
      max_row_q <= max_row_o;
      area_q    <= area_d;
      edge_q    <= edge_d;
      quad_q    <= quad_d;
    end
  end

endmodule

[hdl/binary_blob_shape_features.sv]
// Result path: the frame's last pixel is registered in s1_flags_q, then its result in the output registers.
// Throughput: one pixel per cycle; the line buffer RAM gives one read and one
// write per cycle. Input stalls only when a frame-end pixel meets a result that is
// still waiting at the output. Reset (async, active low) empties the pipeline,
// sets both sizes to 1024 clamped to MAX_WIDTH/MAX_HEIGHT and restarts the frame.
// ---------------------------------------------------------------------------
// Binary blob shape features
// Streams a binary frame and reports bounding box, area, perimeter and Euler number
// ---------------------------------------------------------------------------
`include "binary_blob_shape_features_defines.svh"

module binary_blob_shape_features
  import bbsf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      object_pixel_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [LEFT_W-1:0]         left_col_o,
  output logic [RIGHT_W-1:0]        right_col_o,
  output logic [TOP_W-1:0]          top_row_o,
  output logic [BOTTOM_W-1:0]       bottom_row_o,
  output logic [AREA_W-1:0]         object_area_o,
  output logic [PERIM_W-1:0]        perimeter_edges_o,
  output logic signed [EULER_W-1:0] euler_number_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned SW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HSW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WIDTH_RST  = (CFG_SIZE_RST > MAX_WIDTH) ? MAX_WIDTH : CFG_SIZE_RST;
  localparam int unsigned HEIGHT_RST = (CFG_SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT : CFG_SIZE_RST;

  logic [SW-1:0]  width_q, width_d;
  logic [HSW-1:0] height_q, height_d;
  logic           cfg_hit;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic           last_col, last_row;
  logic           left_q, upleft_q, up_pix;
  logic [0:0]     ram_rdata;
  logic           in_accept;

  logic           s1_valid_q, s1_adv, s1_fire, out_load;
  px_flags_t      s1_flags_q;
  logic [CW-1:0]  s1_col_q;
  logic [RW-1:0]  s1_row_q;

  logic [SW-1:0]  f_min_col;
  logic [CW-1:0]  f_max_col;
  logic [HSW-1:0] f_min_row;
  logic [RW-1:0]  f_max_row;
  logic [AREA_W-1:0]         f_area;
  logic [PERIM_W-1:0]        f_perim;
  logic signed [EULER_W-1:0] f_euler;

  logic                      out_valid_q;
  logic [LEFT_W-1:0]         left_col_q;
  logic [RIGHT_W-1:0]        right_col_q;
  logic [TOP_W-1:0]          top_row_q;
  logic [BOTTOM_W-1:0]       bottom_row_q;
  logic [AREA_W-1:0]         area_q;
  logic [PERIM_W-1:0]        perim_q;
  logic signed [EULER_W-1:0] euler_q;

  // size registers hold the clamped value
  always_comb begin
    cfg_hit  = cfg_we_i && ((cfg_index_i == CFG_IMAGE_WIDTH) ||
                            (cfg_index_i == CFG_IMAGE_HEIGHT));
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i && (cfg_index_i == CFG_IMAGE_WIDTH)) begin
      if (cfg_data_i == '0) begin
        width_d = SW'(1);
      end else if (32'(cfg_data_i) > MAX_WIDTH) begin
        width_d = SW'(MAX_WIDTH);
      end else begin
        width_d = SW'(cfg_data_i);
      end
    end
    if (cfg_we_i && (cfg_index_i == CFG_IMAGE_HEIGHT)) begin
      if (cfg_data_i == '0) begin
        height_d = HSW'(1);
      end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
        height_d = HSW'(MAX_HEIGHT);
      end else begin
        height_d = HSW'(cfg_data_i);
      end
    end
  end

  // output slot frees when empty or taken this cycle
  assign s1_adv     = !s1_valid_q || !s1_flags_q.last || !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign out_load   = s1_fire && s1_flags_q.last;
  assign in_stall_o = !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign last_col = (SW'(col_q) == (width_q - SW'(1)));
  assign last_row = (HSW'(row_q) == (height_q - HSW'(1)));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (in_accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // a one-pixel-wide frame has the pixel above as the previous pixel
  always_comb begin
    if (row_q == '0) begin
      up_pix = 1'b0;
    end else if (width_q == SW'(1)) begin
      up_pix = left_q;
    end else begin
      up_pix = ram_rdata[0];
    end
  end

  // line buffer, read one column ahead
  bbsf_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (col_q),
    .wdata_i (object_pixel_i),
    .re_i    (in_accept),
    .raddr_i (col_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= SW'(WIDTH_RST);
      height_q   <= HSW'(HEIGHT_RST);
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= 1'b0;
      upleft_q   <= 1'b0;
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      if (in_accept) begin
        left_q   <= object_pixel_i;
        upleft_q <= up_pix;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_flags_q.pix    <= object_pixel_i;
      s1_flags_q.up     <= up_pix;
      s1_flags_q.left   <= left_q;
      s1_flags_q.upleft <= upleft_q;
      s1_flags_q.col_nz <= (col_q != '0);
      s1_flags_q.row_nz <= (row_q != '0);
      s1_flags_q.first  <= (col_q == '0) && (row_q == '0);
      s1_flags_q.last   <= last_col && last_row;
      s1_col_q          <= col_q;
      s1_row_q          <= row_q;
    end
    if (out_load) begin
      left_col_q   <= LEFT_W'(f_min_col);
      right_col_q  <= RIGHT_W'(f_max_col);
      top_row_q    <= TOP_W'(f_min_row);
      bottom_row_q <= BOTTOM_W'(f_max_row);
      area_q       <= f_area;
      perim_q      <= f_perim;
      euler_q      <= f_euler;
    end
  end

  bbsf_feat #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_feat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_fire),
    .flags_i   (s1_flags_q),
    .col_i     (s1_col_q),
    .row_i     (s1_row_q),
    .width_i   (width_q),
    .height_i  (height_q),
    .min_col_o (f_min_col),
    .max_col_o (f_max_col),
    .min_row_o (f_min_row),
    .max_row_o (f_max_row),
    .area_o    (f_area),
    .perim_o   (f_perim),
    .euler_o   (f_euler)
  );

  assign out_valid_o       = out_valid_q;
  assign left_col_o        = left_col_q;
  assign right_col_o       = right_col_q;
  assign top_row_o         = top_row_q;
  assign bottom_row_o      = bottom_row_q;
  assign object_area_o     = area_q;
  assign perimeter_edges_o = perim_q;
  assign euler_number_o    = euler_q;

  `BBSF_ASSERT_IMP(a_stall_cause, in_stall_o, s1_valid_q && s1_flags_q.last && out_valid_q, "input stalled without a waiting result")
  `BBSF_ASSERT_IMP(a_result_source, $rose(out_valid_q), $past(s1_valid_q && s1_flags_q.last), "result beat without a frame-end pixel")
  `BBSF_ASSERT_IMP(a_col_range, 1'b1, (SW'(col_q) < width_q) && (HSW'(row_q) < height_q), "position counter beyond frame size")
  `BBSF_ASSERT_NXT(a_cfg_restart, cfg_hit, (col_q == '0) && (row_q == '0), "size write did not restart the frame")

endmodule
